// File: src/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg: shared types, constants and a helper function for the MD5 hasher
// Holds the queue entry type, the control and status structs between the
// back end and the compression engine, and the MD5 constant tables.
// ----------------------------------------------------------------------------
package md5_pkg;

  // Default depth of the word queue between front and back end.
  localparam int unsigned QueueDepth = 4;

  // Largest number of message bytes that one word carries.
  localparam logic [2:0] MaxBytes = 3'd4;

  // One classified message word as it waits in the queue.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        fin;
  } md5_item_t;

  // Commands from the back end to the compression engine.
  typedef struct packed {
    logic start;  // load working words and run 64 steps
    logic init;   // return the chaining words to the initial values
  } cmp_ctrl_t;

  // Status from the compression engine to the back end.
  typedef struct packed {
    logic       busy;
    logic       done;    // chaining words take the new sum at this edge
    logic [3:0] rd_idx;  // block word the engine reads this cycle
  } cmp_stat_t;

  // Initial chaining words; entry 0 is A.
  localparam logic [3:0][31:0] Iv = {
    32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  // Round codes taken from the top two bits of the step number.
  localparam logic [1:0] RoundF = 2'd0;
  localparam logic [1:0] RoundG = 2'd1;
  localparam logic [1:0] RoundH = 2'd2;
  localparam logic [1:0] RoundI = 2'd3;

  // Additive constants, one per step.
  localparam logic [31:0] SineTab [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by round and the low two step bits.
  localparam logic [4:0] RotTab [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Block word that a given step consumes.
  function automatic logic [3:0] msg_index(input logic [5:0] step);
    logic [3:0] n;
    logic [3:0] g;
    n = step[3:0];
    unique case (step[5:4])
      RoundF:  g = n;
      RoundG:  g = (n << 2) + n + 4'd1;
      RoundH:  g = (n << 1) + n + 4'd5;
      RoundI:  g = (n << 3) - n;
      default: g = n;
    endcase
    return g;
  endfunction

endpackage

// File: src/md5_front.sv
// ----------------------------------------------------------------------------
// md5_front: input acceptance and word queue
// Takes message words from the input channel, clamps the byte count and
// holds the classified words in a short queue for the back end.
// ----------------------------------------------------------------------------
module md5_front #(
  parameter int unsigned DEPTH = md5_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       message_word_i,
  input  logic [2:0]        valid_bytes_i,
  input  logic              final_word_i,
  output logic              q_valid_o,
  output md5_pkg::md5_item_t q_item_o,
  input  logic              q_pop_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

  md5_pkg::md5_item_t mem_q [DEPTH];
  md5_pkg::md5_item_t item;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic push;

  // Classify the incoming word: byte counts above four mean a full word.
  always_comb begin
    item.word   = message_word_i;
    item.nbytes = (valid_bytes_i > md5_pkg::MaxBytes) ? md5_pkg::MaxBytes : valid_bytes_i;
    item.fin    = final_word_i;
  end

  assign in_ready_o = (count_q != DepthCnt);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !q_pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push && q_pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

`ifndef SYNTHESIS
  a_pop_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o)
    else $error("queue popped while empty");

  a_empty_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with unequal pointers");

  a_push_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !q_pop_i) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count missed a transfer");
`endif

endmodule

// File: src/md5_compress.sv
// ----------------------------------------------------------------------------
// md5_compress: 64-step MD5 compression engine
// Holds the chaining words and runs one compression step per cycle over the
// block words that the back end supplies, then adds the result back.
// ----------------------------------------------------------------------------
module md5_compress (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  md5_pkg::cmp_ctrl_t      ctrl_i,
  input  logic [31:0]             blk_word_i,
  output md5_pkg::cmp_stat_t      stat_o,
  output logic [3:0][31:0]        chain_o
);

  localparam logic [5:0] LastStep = 6'd63;

  logic [3:0][31:0] chain_q;
  logic [31:0] a_q, b_q, c_q, d_q, km_q, km_d;
  logic [5:0]  step_q, next_step;
  logic        run_q, add_q;
  logic [31:0] fval, tsum, b_new;
  logic [63:0] rot_w;
  logic [4:0]  rot_amt;

  // Round function, sum and rotate for the current step.
  always_comb begin
    unique case (step_q[5:4])
      md5_pkg::RoundF: fval = (b_q & c_q) | (~b_q & d_q);
      md5_pkg::RoundG: fval = (d_q & b_q) | (~d_q & c_q);
      md5_pkg::RoundH: fval = b_q ^ c_q ^ d_q;
      md5_pkg::RoundI: fval = c_q ^ (b_q | ~d_q);
      default:         fval = b_q ^ c_q ^ d_q;
    endcase
    tsum    = a_q + fval + km_q;
    rot_amt = md5_pkg::RotTab[{step_q[5:4], step_q[1:0]}];
    rot_w   = {tsum, tsum} << rot_amt;
    b_new   = b_q + rot_w[63:32];
  end

  // Constant plus message word for the following step, registered ahead.
  assign next_step = run_q ? step_q + 6'd1 : 6'd0;
  assign km_d      = md5_pkg::SineTab[next_step] + blk_word_i;

  assign stat_o.busy   = run_q | add_q;
  assign stat_o.done   = add_q;
  assign stat_o.rd_idx = md5_pkg::msg_index(next_step);
  assign chain_o       = chain_q;

  // Step sequencing and chaining words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      add_q   <= 1'b0;
      step_q  <= '0;
      chain_q <= md5_pkg::Iv;
    end else begin
      add_q <= !ctrl_i.start && run_q && (step_q == LastStep);
      if (ctrl_i.start) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 6'd1;
        if (step_q == LastStep) begin
          run_q <= 1'b0;
        end
      end
      if (ctrl_i.init) begin
        chain_q <= md5_pkg::Iv;
      end else if (add_q) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
      end
    end
  end

  // Working words.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      a_q  <= chain_q[0];
      b_q  <= chain_q[1];
      c_q  <= chain_q[2];
      d_q  <= chain_q[3];
      km_q <= km_d;
    end else if (run_q) begin
      a_q  <= d_q;
      b_q  <= b_new;
      c_q  <= b_q;
      d_q  <= c_q;
      km_q <= km_d;
    end
  end

endmodule

// File: src/md5_back.sv
// ----------------------------------------------------------------------------
// md5_back: block assembly, padding and digest output
// Packs queued bytes into the 16-word block, starts compressions, applies
// the final padding and length, and hands out the four digest words.
// ----------------------------------------------------------------------------
module md5_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  md5_pkg::md5_item_t q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        digest_word_o,
  output logic [1:0]         word_position_o,
  output logic               digest_done_o
);

  localparam logic [1:0] S_FILL = 2'd0;
  localparam logic [1:0] S_ZERO = 2'd1;
  localparam logic [1:0] S_COMP = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [6:0]  BlockBytes = 7'd64;
  localparam logic [5:0]  LenPos     = 6'd56;
  localparam logic [31:0] PadByte    = 32'h0000_0080;
  localparam logic [1:0]  LastWord   = 2'd3;

  logic [1:0]  state_q, state_d, ret_q, ret_d;
  logic [5:0]  fill_q, fill_d;
  logic [31:0] pend_q, pend_d;
  logic [2:0]  npend_q, npend_d;
  logic        fin_q, fin_d, pad_q, pad_d;
  logic [63:0] len_q, len_d;
  logic [1:0]  oidx_q, oidx_d;
  logic        out_valid_q, out_done_q, out_load;
  logic [31:0] out_word_q;
  logic [1:0]  out_pos_q;

  logic [31:0] blk_q [16];
  logic [3:0]  blk_be [16];
  logic [31:0] blk_wd [16];

  logic [31:0] ins_data;
  logic [2:0]  ins_n, ins_m;
  logic [6:0]  ins_lim, room, fill_sum;
  logic [3:0]  bmask, lo, hi;
  logic [63:0] wide_data;
  logic [7:0]  wide_be;
  logic        ins_we, len_we;

  md5_pkg::cmp_ctrl_t cmp_ctrl;
  md5_pkg::cmp_stat_t cmp_stat;
  logic [3:0][31:0]   chain;

  md5_compress u_compress (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (cmp_ctrl),
    .blk_word_i (blk_q[cmp_stat.rd_idx]),
    .stat_o     (cmp_stat),
    .chain_o    (chain)
  );

  // Byte insertion: how many bytes fit, and where they land in the block.
  always_comb begin
    ins_data = pend_q;
    ins_n    = npend_q;
    ins_lim  = BlockBytes;
    if (state_q == S_ZERO) begin
      ins_data = '0;
      ins_n    = md5_pkg::MaxBytes;
      ins_lim  = (fill_q <= LenPos) ? {1'b0, LenPos} : BlockBytes;
    end
    room      = ins_lim - {1'b0, fill_q};
    ins_m     = ({4'b0, ins_n} > room) ? room[2:0] : ins_n;
    bmask     = 4'((5'd1 << ins_m) - 5'd1);
    wide_data = {32'b0, ins_data} << {fill_q[1:0], 3'b000};
    wide_be   = {4'b0, bmask} << fill_q[1:0];
    fill_sum  = {1'b0, fill_q} + {4'b0, ins_m};
    lo        = fill_q[5:2];
    hi        = lo + 4'd1;
  end

  // Byte enables per block word; a transfer may straddle two words.
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      blk_be[j] = '0;
      blk_wd[j] = wide_data[31:0];
      if (ins_we) begin
        if (4'(j) == lo) begin
          blk_be[j] = wide_be[3:0];
        end else if (4'(j) == hi) begin
          blk_be[j] = wide_be[7:4];
          blk_wd[j] = wide_data[63:32];
        end
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    fill_d   = fill_q;
    pend_d   = pend_q;
    npend_d  = npend_q;
    fin_d    = fin_q;
    pad_d    = pad_q;
    len_d    = len_q;
    oidx_d   = oidx_q;
    ins_we   = 1'b0;
    len_we   = 1'b0;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    cmp_ctrl = '0;
    unique case (state_q)
      S_FILL: begin
        if (npend_q != '0) begin
          ins_we  = 1'b1;
          pend_d  = pend_q >> {ins_m, 3'b000};
          npend_d = npend_q - ins_m;
          if (fill_sum == BlockBytes) begin
            fill_d         = '0;
            cmp_ctrl.start = 1'b1;
            ret_d          = S_FILL;
            state_d        = S_COMP;
          end else begin
            fill_d = fill_sum[5:0];
          end
        end else if (fin_q && !pad_q) begin
          pend_d  = PadByte;
          npend_d = 3'd1;
          pad_d   = 1'b1;
        end else if (fin_q) begin
          state_d = S_ZERO;
        end
        // Take the next word once the current one is used up.
        if (!fin_q && q_valid_i &&
            (npend_q == '0 || (ins_m == npend_q && fill_sum != BlockBytes))) begin
          q_pop_o = 1'b1;
          pend_d  = q_item_i.word;
          npend_d = q_item_i.nbytes;
          fin_d   = q_item_i.fin;
          len_d   = len_q + {58'b0, q_item_i.nbytes, 3'b000};
        end
      end
      S_ZERO: begin
        if (fill_q == LenPos) begin
          len_we         = 1'b1;
          fill_d         = '0;
          cmp_ctrl.start = 1'b1;
          ret_d          = S_OUT;
          state_d        = S_COMP;
        end else begin
          ins_we = 1'b1;
          if (fill_sum == BlockBytes) begin
            fill_d         = '0;
            cmp_ctrl.start = 1'b1;
            ret_d          = S_ZERO;
            state_d        = S_COMP;
          end else begin
            fill_d = fill_sum[5:0];
          end
        end
      end
      S_COMP: begin
        if (cmp_stat.done) begin
          state_d = ret_q;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          oidx_d   = oidx_q + 2'd1;
          if (oidx_q == LastWord) begin
            cmp_ctrl.init = 1'b1;
            len_d         = '0;
            fill_d        = '0;
            fin_d         = 1'b0;
            pad_d         = 1'b0;
            npend_d       = '0;
            state_d       = S_FILL;
          end
        end
      end
      default: state_d = S_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      ret_q       <= S_FILL;
      fill_q      <= '0;
      npend_q     <= '0;
      fin_q       <= 1'b0;
      pad_q       <= 1'b0;
      len_q       <= '0;
      oidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      npend_q <= npend_d;
      fin_q   <= fin_d;
      pad_q   <= pad_d;
      len_q   <= len_d;
      oidx_q  <= oidx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pending bytes and output payload.
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (out_load) begin
      out_word_q <= chain[oidx_q];
      out_pos_q  <= oidx_q;
      out_done_q <= (oidx_q == LastWord);
    end
  end

  // Block buffer with byte writes; the length goes into the last two words.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 16; j++) begin
      for (int k = 0; k < 4; k++) begin
        if (blk_be[j][k]) begin
          blk_q[j][8*k +: 8] <= blk_wd[j][8*k +: 8];
        end
      end
    end
    if (len_we) begin
      blk_q[14] <= len_q[31:0];
      blk_q[15] <= len_q[63:32];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign digest_word_o   = out_word_q;
  assign word_position_o = out_pos_q;
  assign digest_done_o   = out_done_q;

`ifndef SYNTHESIS
  a_engine_in_comp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_stat.busy |-> (state_q == S_COMP))
    else $error("compression running outside the wait state");

  a_done_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && digest_done_o) |-> (word_position_o == LastWord))
    else $error("digest end flag on a word other than D");

  a_out_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (fill_q == '0 && npend_q == '0))
    else $error("digest output with bytes still pending");

  a_pad_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_q |-> fin_q)
    else $error("padding started without a final word");
`endif

endmodule

// File: src/md5_stream_hasher.sv
// ----------------------------------------------------------------------------
// md5_stream_hasher: streaming MD5 digest engine
// Front end and word queue feeding the block assembly and compression back
// end.
// ----------------------------------------------------------------------------
// Message words enter as 32-bit little-endian words carrying 0 to 4 bytes;
// a word marked final closes the message and yields four digest words A, B,
// C and D (D flagged as the last), after which the state returns to the
// initial values. Every completed 64-byte block holds the back end in the
// compression engine for its 64 steps, at one per cycle, and the final
// addition. A final word adds padding and length insertion, one or two
// compressions, and four digest transfers. The input queue of QUEUE_DEPTH
// words keeps accepting, until it is full, while the back end compresses.
// No clearing pass follows reset.
module md5_stream_hasher #(
  parameter int unsigned QUEUE_DEPTH = md5_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] message_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        final_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [1:0]  word_position_o,
  output logic        digest_done_o
);

  logic               q_valid;
  logic               q_pop;
  md5_pkg::md5_item_t q_item;

  // Input acceptance and queue.
  md5_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .message_word_i (message_word_i),
    .valid_bytes_i  (valid_bytes_i),
    .final_word_i   (final_word_i),
    .q_valid_o      (q_valid),
    .q_item_o       (q_item),
    .q_pop_i        (q_pop)
  );

  // Block assembly, compression and digest output.
  md5_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .digest_word_o   (digest_word_o),
    .word_position_o (word_position_o),
    .digest_done_o   (digest_done_o)
  );

endmodule
